FILE: hdl/apu_pkg.sv
// Shared types, codes and constants of the Adam parameter update block.
// The other design files, apart from apu_ram and apu_sqrt, use this package through scoped names.
`default_nettype none

package apu_pkg;

	// Size of the parameter table.
	localparam int NUM_PARAMS = 256;
	localparam int ADDR_W = (NUM_PARAMS > 1) ? $clog2(NUM_PARAMS) : 1;

	// Operation codes of an input item.
	localparam logic [1:0] FUNC_LOAD   = 2'd0;
	localparam logic [1:0] FUNC_UPDATE = 2'd1;
	localparam logic [1:0] FUNC_READ   = 2'd2;

	// Status codes of a result item.
	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_REFUSED = 2'd1;
	localparam logic [1:0] STAT_SAT     = 2'd2;

	// Register indexes on the configuration port (byte address / 4).
	localparam logic [2:0] REG_LR    = 3'd0;
	localparam logic [2:0] REG_BETA1 = 3'd1;
	localparam logic [2:0] REG_BETA2 = 3'd2;
	localparam logic [2:0] REG_EPS   = 3'd3;
	localparam logic [2:0] REG_LIMIT = 3'd4;

	// Fixed-point constants.
	localparam logic [32:0] ONE_Q32   = 33'h1_0000_0000;
	localparam logic [48:0] RATIO_CAP = 49'h1_0000_0000_0000;

	// Input and result items.
	typedef struct packed {
		logic [1:0]         func;
		logic [7:0]         entry_index;
		logic signed [31:0] operand;
		logic               step_end;
	} cmd_t;

	typedef struct packed {
		logic [7:0]         result_index;
		logic signed [31:0] param_value;
		logic [19:0]        step_number;
		logic [1:0]         status;
	} res_t;

	// Classified operation, as queued between front and back.
	typedef enum logic [1:0] {
		KIND_LOAD,
		KIND_UPDATE,
		KIND_READ,
		KIND_NONE
	} kind_t;

	typedef struct packed {
		kind_t              kind;
		logic [7:0]         idx;
		logic signed [31:0] operand;
		logic               step_end;
	} op_t;

	typedef struct packed {
		logic valid;
		op_t  op;
	} queue_head_t;

	// Configuration register values.
	typedef struct packed {
		logic [15:0] lr;
		logic [15:0] beta1;
		logic [15:0] beta2;
		logic [15:0] eps;
		logic [19:0] limit;
	} cfg_t;

	// Divider request: dividend is {hi, lo}, hi must stay below divisor to avoid saturation.
	typedef struct packed {
		logic [31:0] hi;
		logic [63:0] lo;
		logic [33:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic        sat;
		logic [63:0] quot;
	} div_rsp_t;

	// Sequencer states of the back part.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FETCH,
		ST_MOM,
		ST_VDIV,
		ST_ROOT,
		ST_MDIV,
		ST_RDIV,
		ST_STEP,
		ST_WB
	} state_t;

endpackage

`default_nettype wire

FILE: hdl/apu_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Stand-alone; no package needed.
`default_nettype none

module apu_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

FILE: hdl/apu_front.sv
// Front part: accepts input items, classifies them and holds them in a two-entry queue.
// Depends on apu_pkg.
`default_nettype none

module apu_front (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cmd_valid,
	output logic                      cmd_stall,
	input  wire apu_pkg::cmd_t        cmd,
	output apu_pkg::queue_head_t      head,
	input  wire logic                 pop
);

	apu_pkg::op_t slot_q [2];
	logic         wr_ptr_q;
	logic         rd_ptr_q;
	logic [1:0]   count_q;
	apu_pkg::op_t op_new;
	logic         push;

	// Classify the incoming item; an unused code acts as a read.
	always_comb begin
		op_new.idx      = cmd.entry_index;
		op_new.operand  = cmd.operand;
		op_new.step_end = cmd.step_end;
		unique case (cmd.func)
			apu_pkg::FUNC_LOAD:   op_new.kind = apu_pkg::KIND_LOAD;
			apu_pkg::FUNC_UPDATE: op_new.kind = apu_pkg::KIND_UPDATE;
			default:              op_new.kind = apu_pkg::KIND_READ;
		endcase
		if (32'(cmd.entry_index) >= apu_pkg::NUM_PARAMS) begin
			op_new.kind = apu_pkg::KIND_NONE;
		end
	end

	assign cmd_stall  = (count_q == 2'd2);
	assign push       = cmd_valid && !cmd_stall;
	assign head.valid = (count_q != 2'd0);
	assign head.op    = slot_q[rd_ptr_q];

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= op_new;
		end
	end

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: hdl/apu_div.sv
// Restoring divider, two quotient bits per cycle, 64-bit quotient with saturation.
// Depends on apu_pkg for its request and response types.
`default_nettype none

module apu_div (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire apu_pkg::div_req_t req,
	output apu_pkg::div_rsp_t      rsp
);

	logic        busy_q;
	logic        chk_q;
	logic        done_q;
	logic [4:0]  cnt_q;
	logic [33:0] rem_q;
	logic [63:0] lo_q;
	logic [33:0] dvs_q;
	logic        sat_q;
	logic [33:0] rem_nx;
	logic [63:0] lo_nx;
	logic        over;

	// The quotient overflows 64 bits when the upper dividend part reaches the divisor.
	assign over = (rem_q >= dvs_q);

	// Two compare-subtract steps; quotient bits shift in where dividend bits leave.
	always_comb begin
		logic [34:0] t;
		logic [33:0] r;
		logic [63:0] q;
		r = rem_q;
		q = lo_q;
		for (int k = 0; k < 2; k++) begin
			t = {r, q[63]};
			q = {q[62:0], 1'b0};
			if (t >= {1'b0, dvs_q}) begin
				t    = t - {1'b0, dvs_q};
				q[0] = 1'b1;
			end
			r = t[33:0];
		end
		rem_nx = r;
		lo_nx  = q;
	end

	// Control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			chk_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 5'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				chk_q  <= 1'b1;
				cnt_q  <= 5'd0;
			end else if (busy_q && chk_q) begin
				chk_q <= 1'b0;
				if (over) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= 34'(req.hi);
			lo_q  <= req.lo;
			dvs_q <= req.divisor;
			sat_q <= 1'b0;
		end else if (busy_q && chk_q) begin
			if (over) begin
				sat_q <= 1'b1;
				lo_q  <= '1;
			end
		end else if (busy_q) begin
			rem_q <= rem_nx;
			lo_q  <= lo_nx;
		end
	end

	assign rsp.done = done_q;
	assign rsp.sat  = sat_q;
	assign rsp.quot = lo_q;

endmodule

`default_nettype wire

FILE: hdl/apu_sqrt.sv
// Digit-by-digit integer square root of a 64-bit value, two root bits per cycle.
// Stand-alone; no package needed.
`default_nettype none

module apu_sqrt (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] radicand,
	output logic             done,
	output logic [31:0]      root
);

	logic        busy_q;
	logic        done_q;
	logic [3:0]  cnt_q;
	logic [63:0] x_q;
	logic [33:0] rem_q;
	logic [31:0] root_q;
	logic [63:0] x_nx;
	logic [33:0] rem_nx;
	logic [31:0] root_nx;

	// Two steps of the restoring root recurrence.
	always_comb begin
		logic [35:0] t;
		logic [35:0] trial;
		logic [33:0] r;
		logic [31:0] rt;
		logic [63:0] x;
		r  = rem_q;
		rt = root_q;
		x  = x_q;
		for (int k = 0; k < 2; k++) begin
			t     = {r, x[63:62]};
			x     = {x[61:0], 2'b00};
			trial = {2'b00, rt, 2'b01};
			if (t >= trial) begin
				t  = t - trial;
				rt = {rt[30:0], 1'b1};
			end else begin
				rt = {rt[30:0], 1'b0};
			end
			r = t[33:0];
		end
		x_nx    = x;
		rem_nx  = r;
		root_nx = rt;
	end

	// Control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 4'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 4'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 4'd1;
				if (cnt_q == 4'd15) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath.
	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= radicand;
			rem_q  <= 34'd0;
			root_q <= 32'd0;
		end else if (busy_q) begin
			x_q    <= x_nx;
			rem_q  <= rem_nx;
			root_q <= root_nx;
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

`default_nettype wire

FILE: hdl/apu_back.sv
// Back part: sequencer that carries out load, update and read on the parameter table,
// with moment memories, divider, square root and the result register.
// Depends on apu_pkg, apu_ram, apu_div and apu_sqrt.
`default_nettype none

module apu_back (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire apu_pkg::cfg_t        cfg,
	input  wire apu_pkg::queue_head_t head,
	output logic                      pop,
	output logic                      res_valid,
	input  wire logic                 res_stall,
	output apu_pkg::res_t             res
);

	apu_pkg::state_t state_q, state_d;
	apu_pkg::op_t    cur_q;

	// Optimizer state.
	logic [19:0] step_count_q;
	logic [32:0] pow1_q;
	logic [32:0] pow2_q;
	logic [apu_pkg::NUM_PARAMS-1:0] valid_q;
	logic        rd_valid_q;

	// Memory ports.
	logic [apu_pkg::ADDR_W-1:0] raddr;
	logic [apu_pkg::ADDR_W-1:0] waddr;
	logic        we;
	logic [31:0] wr_param;
	logic [31:0] wr_mean;
	logic [47:0] wr_sq;
	logic [31:0] param_rd;
	logic [31:0] mean_rd;
	logic [47:0] sq_rd;

	// Datapath registers.
	logic signed [31:0] value_q;
	logic signed [31:0] m_q;
	logic [46:0] g2_q;
	logic [47:0] sq_old_q;
	logic [32:0] p1_q;
	logic [32:0] p2_q;
	logic [47:0] v_q;
	logic [32:0] c1_q;
	logic [31:0] am_q;
	logic        vsat_q;
	logic [33:0] den_q;
	logic [48:0] ratio_q;
	logic [48:0] step_q;

	// Result register.
	logic          res_valid_q;
	apu_pkg::res_t res_q;
	apu_pkg::res_t res_d;
	logic          res_load;
	logic          out_free;

	// Shared arithmetic units.
	logic              div_start;
	apu_pkg::div_req_t div_req;
	apu_pkg::div_rsp_t div_rsp;
	logic              sq_start;
	logic              sq_done;
	logic [31:0]       sq_root;

	// Combinational datapath values.
	logic signed [31:0] mean_old;
	logic [47:0]        sq_now;
	logic [31:0]        ag;
	logic [63:0]        g2_full;
	logic signed [17:0] b1_s;
	logic signed [17:0] wb1_s;
	logic signed [49:0] m_a;
	logic signed [49:0] m_b;
	logic signed [50:0] m_sum;
	logic [48:0]        p1_full;
	logic [48:0]        p2_full;
	logic [16:0]        wb2;
	logic [63:0]        v_a;
	logic [63:0]        v_b;
	logic [64:0]        v_sum;
	logic [47:0]        v_new;
	logic [32:0]        c1_new;
	logic [32:0]        c2_new;
	logic [31:0]        am_new;
	logic [33:0]        den_sum;
	logic [33:0]        den_new;
	logic [48:0]        ratio_new;
	logic [64:0]        step_full;
	logic signed [50:0] v_ext;
	logic signed [50:0] s_ext;
	logic signed [50:0] nv;
	logic signed [31:0] nv_clamp;
	logic               nv_sat;
	logic               refused;
	logic [19:0]        step_next;

	assign raddr    = apu_pkg::ADDR_W'(head.op.idx);
	assign waddr    = apu_pkg::ADDR_W'(cur_q.idx);
	assign out_free = !res_valid_q || !res_stall;
	assign refused  = (step_count_q >= cfg.limit);

	apu_ram #(.WIDTH(32), .DEPTH(apu_pkg::NUM_PARAMS)) u_param_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wr_param),
		.raddr (raddr),
		.rdata (param_rd)
	);

	apu_ram #(.WIDTH(32), .DEPTH(apu_pkg::NUM_PARAMS)) u_mean_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wr_mean),
		.raddr (raddr),
		.rdata (mean_rd)
	);

	apu_ram #(.WIDTH(48), .DEPTH(apu_pkg::NUM_PARAMS)) u_square_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wr_sq),
		.raddr (raddr),
		.rdata (sq_rd)
	);

	apu_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	apu_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start),
		.radicand (div_rsp.quot),
		.done     (sq_done),
		.root     (sq_root)
	);

	// Moments of an entry never written read as zero.
	assign mean_old = rd_valid_q ? signed'(mean_rd) : 32'sd0;
	assign sq_now   = rd_valid_q ? sq_rd : 48'd0;

	// Fetch stage: gradient square, new mean moment, next decay powers.
	always_comb begin
		ag      = cur_q.operand[31] ? (~cur_q.operand + 32'd1) : cur_q.operand;
		g2_full = ag * ag;
		b1_s    = signed'({2'b00, cfg.beta1});
		wb1_s   = 18'sd65536 - b1_s;
		m_a     = b1_s * mean_old;
		m_b     = wb1_s * cur_q.operand;
		m_sum   = 51'(m_a) + 51'(m_b);
		p1_full = pow1_q * cfg.beta1;
		p2_full = pow2_q * cfg.beta2;
	end

	// Moment stage: new square moment and bias-correction divisors.
	always_comb begin
		wb2    = 17'h10000 - {1'b0, cfg.beta2};
		v_a    = sq_old_q * cfg.beta2;
		v_b    = g2_q * wb2;
		v_sum  = 65'(v_a) + 65'(v_b);
		v_new  = v_sum[63:16];
		c1_new = apu_pkg::ONE_Q32 - p1_q;
		c2_new = apu_pkg::ONE_Q32 - p2_q;
		am_new = m_q[31] ? (~m_q + 32'd1) : m_q;
	end

	// Denominator, ratio cap, step size and the new saturated value.
	always_comb begin
		den_sum   = 34'(sq_root) + 34'(cfg.eps);
		den_new   = (den_sum == 34'd0) ? 34'd1 : den_sum;
		ratio_new = (div_rsp.sat || div_rsp.quot > 64'(apu_pkg::RATIO_CAP))
			? apu_pkg::RATIO_CAP : div_rsp.quot[48:0];
		step_full = ratio_q * cfg.lr;
		v_ext     = 51'(value_q);
		s_ext     = signed'({2'b00, step_q});
		nv        = m_q[31] ? (v_ext + s_ext) : (v_ext - s_ext);
		nv_sat    = 1'b0;
		if (nv > 51'sd2147483647) begin
			nv_clamp = 32'sh7fffffff;
			nv_sat   = 1'b1;
		end else if (nv < -51'sd2147483648) begin
			nv_clamp = 32'sh80000000;
			nv_sat   = 1'b1;
		end else begin
			nv_clamp = nv[31:0];
		end
		step_next = cur_q.step_end ? (step_count_q + 20'd1) : step_count_q;
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			apu_pkg::ST_IDLE: begin
				if (head.valid && out_free) begin
					state_d = apu_pkg::ST_FETCH;
				end
			end
			apu_pkg::ST_FETCH: begin
				if (cur_q.kind == apu_pkg::KIND_UPDATE && !refused) begin
					state_d = apu_pkg::ST_MOM;
				end else begin
					state_d = apu_pkg::ST_IDLE;
				end
			end
			apu_pkg::ST_MOM:  state_d = apu_pkg::ST_VDIV;
			apu_pkg::ST_VDIV: begin
				if (div_rsp.done) begin
					state_d = apu_pkg::ST_ROOT;
				end
			end
			apu_pkg::ST_ROOT: begin
				if (sq_done) begin
					state_d = apu_pkg::ST_MDIV;
				end
			end
			apu_pkg::ST_MDIV: begin
				if (div_rsp.done) begin
					state_d = apu_pkg::ST_RDIV;
				end
			end
			apu_pkg::ST_RDIV: begin
				if (div_rsp.done) begin
					state_d = apu_pkg::ST_STEP;
				end
			end
			apu_pkg::ST_STEP: state_d = apu_pkg::ST_WB;
			apu_pkg::ST_WB:   state_d = apu_pkg::ST_IDLE;
			default:          state_d = apu_pkg::ST_IDLE;
		endcase
	end

	// Outputs of the sequencer.
	always_comb begin
		pop       = 1'b0;
		div_start = 1'b0;
		div_req   = '0;
		sq_start  = 1'b0;
		we        = 1'b0;
		wr_param  = 32'd0;
		wr_mean   = 32'd0;
		wr_sq     = 48'd0;
		res_load  = 1'b0;
		res_d.result_index = cur_q.idx;
		res_d.param_value  = 32'sd0;
		res_d.step_number  = step_count_q;
		res_d.status       = apu_pkg::STAT_OK;
		unique case (state_q)
			apu_pkg::ST_IDLE: begin
				pop = head.valid && out_free;
			end
			apu_pkg::ST_FETCH: begin
				unique case (cur_q.kind)
					apu_pkg::KIND_LOAD: begin
						we                = 1'b1;
						wr_param          = cur_q.operand;
						res_load          = 1'b1;
						res_d.param_value = cur_q.operand;
						res_d.step_number = 20'd1;
					end
					apu_pkg::KIND_UPDATE: begin
						if (refused) begin
							res_load          = 1'b1;
							res_d.param_value = signed'(param_rd);
							res_d.status      = apu_pkg::STAT_REFUSED;
						end
					end
					apu_pkg::KIND_READ: begin
						res_load          = 1'b1;
						res_d.param_value = signed'(param_rd);
					end
					default: begin
						res_load = 1'b1;
					end
				endcase
			end
			apu_pkg::ST_MOM: begin
				// Bias-corrected square moment: v * 2^48 / c2.
				div_start       = 1'b1;
				div_req.hi      = v_new[47:16];
				div_req.lo      = {v_new[15:0], 48'd0};
				div_req.divisor = {1'b0, c2_new};
			end
			apu_pkg::ST_VDIV: begin
				sq_start = div_rsp.done;
			end
			apu_pkg::ST_ROOT: begin
				// Bias-corrected mean magnitude: |m| * 2^32 / c1.
				div_start       = sq_done;
				div_req.hi      = 32'd0;
				div_req.lo      = {am_q, 32'd0};
				div_req.divisor = {1'b0, c1_q};
			end
			apu_pkg::ST_MDIV: begin
				// Ratio: m_hat * 2^16 / (root + epsilon).
				div_start       = div_rsp.done;
				div_req.hi      = 32'(div_rsp.quot[63:48]);
				div_req.lo      = {div_rsp.quot[47:0], 16'd0};
				div_req.divisor = den_q;
			end
			apu_pkg::ST_WB: begin
				we                = 1'b1;
				wr_param          = nv_clamp;
				wr_mean           = m_q;
				wr_sq             = v_q;
				res_load          = 1'b1;
				res_d.param_value = nv_clamp;
				res_d.step_number = step_next;
				res_d.status      = (vsat_q || nv_sat) ? apu_pkg::STAT_SAT : apu_pkg::STAT_OK;
			end
			default: begin
				pop = 1'b0;
			end
		endcase
	end

	// Control and optimizer state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= apu_pkg::ST_IDLE;
			step_count_q <= 20'd1;
			pow1_q       <= apu_pkg::ONE_Q32;
			pow2_q       <= apu_pkg::ONE_Q32;
			valid_q      <= '0;
			res_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (we) begin
				valid_q[waddr] <= 1'b1;
			end
			if (state_q == apu_pkg::ST_FETCH && cur_q.kind == apu_pkg::KIND_LOAD) begin
				step_count_q <= 20'd1;
				pow1_q       <= apu_pkg::ONE_Q32;
				pow2_q       <= apu_pkg::ONE_Q32;
			end
			if (state_q == apu_pkg::ST_WB && cur_q.step_end) begin
				step_count_q <= step_next;
				pow1_q       <= p1_q;
				pow2_q       <= p2_q;
			end
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers, loaded as the sequencer passes each stage.
	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q      <= head.op;
			rd_valid_q <= valid_q[raddr];
		end
		if (state_q == apu_pkg::ST_FETCH) begin
			value_q  <= signed'(param_rd);
			m_q      <= m_sum[47:16];
			g2_q     <= g2_full[62:16];
			sq_old_q <= sq_now;
			p1_q     <= p1_full[48:16];
			p2_q     <= p2_full[48:16];
		end
		if (state_q == apu_pkg::ST_MOM) begin
			v_q  <= v_new;
			c1_q <= c1_new;
			am_q <= am_new;
		end
		if (state_q == apu_pkg::ST_VDIV && div_rsp.done) begin
			vsat_q <= div_rsp.sat;
		end
		if (state_q == apu_pkg::ST_ROOT && sq_done) begin
			den_q <= den_new;
		end
		if (state_q == apu_pkg::ST_RDIV && div_rsp.done) begin
			ratio_q <= ratio_new;
		end
		if (state_q == apu_pkg::ST_STEP) begin
			step_q <= step_full[64:16];
		end
		if (res_load) begin
			res_q <= res_d;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

`default_nettype wire

FILE: hdl/adam_parameter_update.sv
// Top level of the Adam parameter update block: configuration registers, front and back.
// Depends on apu_pkg, apu_front and apu_back.
//
//   Channel   Handshake               Payload
//   cmd       cmd_valid / cmd_stall   apu_pkg::cmd_t (func, entry_index, operand, step_end)
//   res       res_valid / res_stall   apu_pkg::res_t (result_index, param_value, step_number,
//                                     status)
//   config    APB write/read          learning_rate .. step_limit at byte address 4*i
//
// A load, a read or a refused update writes the result register from the fetch state.
// An update runs the divider, two quotient bits a cycle, three times in turn, with the
// square root between the first and the second division.
// Reset clears the moments through per-entry valid bits; no clearing pass is needed.
// The two-entry queue accepts items while the back part works or its result stalls, until full.
`default_nettype none

module adam_parameter_update (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cmd_valid,
	output logic               cmd_stall,
	input  wire apu_pkg::cmd_t cmd,
	output logic               res_valid,
	input  wire logic          res_stall,
	output apu_pkg::res_t      res,
	input  wire logic          psel,
	input  wire logic          penable,
	input  wire logic          pwrite,
	input  wire logic [4:0]    paddr,
	input  wire logic [31:0]   pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	logic [15:0] lr_q;
	logic [15:0] beta1_q;
	logic [15:0] beta2_q;
	logic [15:0] eps_q;
	logic [19:0] limit_q;
	logic        wr_en;
	apu_pkg::cfg_t        cfg;
	apu_pkg::queue_head_t head;
	logic                 pop;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	// Configuration register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lr_q    <= 16'd66;
			beta1_q <= 16'd58982;
			beta2_q <= 16'd65470;
			eps_q   <= 16'd1;
			limit_q <= 20'd1000;
		end else if (wr_en) begin
			case (paddr[4:2])
				apu_pkg::REG_LR:    lr_q    <= pwdata[15:0];
				apu_pkg::REG_BETA1: beta1_q <= pwdata[15:0];
				apu_pkg::REG_BETA2: beta2_q <= pwdata[15:0];
				apu_pkg::REG_EPS:   eps_q   <= pwdata[15:0];
				apu_pkg::REG_LIMIT: limit_q <= pwdata[19:0];
				default:            lr_q    <= lr_q;
			endcase
		end
	end

	// Register read-back.
	always_comb begin
		unique case (paddr[4:2])
			apu_pkg::REG_LR:    prdata = {16'd0, lr_q};
			apu_pkg::REG_BETA1: prdata = {16'd0, beta1_q};
			apu_pkg::REG_BETA2: prdata = {16'd0, beta2_q};
			apu_pkg::REG_EPS:   prdata = {16'd0, eps_q};
			apu_pkg::REG_LIMIT: prdata = {12'd0, limit_q};
			default:            prdata = 32'd0;
		endcase
	end

	assign cfg.lr    = lr_q;
	assign cfg.beta1 = beta1_q;
	assign cfg.beta2 = beta2_q;
	assign cfg.eps   = eps_q;
	assign cfg.limit = limit_q;

	apu_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.head      (head),
		.pop       (pop)
	);

	apu_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.head      (head),
		.pop       (pop),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

endmodule

`default_nettype wire

FILE: tb/adam_parameter_update_tb.sv
// Self-checking testbench of the Adam parameter update block.
// Depends on apu_pkg and adam_parameter_update; predicts every result item in place.
`default_nettype none

module adam_parameter_update_tb;

	localparam int QUIET_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_stall;
	apu_pkg::cmd_t cmd = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	apu_pkg::res_t res;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [4:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	adam_parameter_update u_dut (.*);

	always #5 clk = ~clk;

	// Predictor state and register copies.
	logic [15:0] lr_q, beta1_q, beta2_q, eps_q;
	logic [19:0] limit_q;
	logic signed [31:0] value_tbl [apu_pkg::NUM_PARAMS];
	logic signed [31:0] mean_tbl [apu_pkg::NUM_PARAMS];
	logic [47:0] square_tbl [apu_pkg::NUM_PARAMS];
	bit loaded [apu_pkg::NUM_PARAMS];
	logic [19:0] step_cnt;
	logic [32:0] pow1, pow2;

	apu_pkg::res_t expected_q [$];
	int errors = 0;
	int quiet = 0;
	bit stall_enable = 1'b1;
	bit hold_request = 1'b0;
	bit gap_enable = 1'b1;

	// floor(num * 2^sh / den), saturating at all ones.
	function automatic logic [63:0] scaled_div(input logic [63:0] num, input int sh,
			input logic [63:0] den, inout bit sat);
		logic [63:0] q, r;
		q = num / den;
		r = num % den;
		for (int k = 0; k < sh; k++) begin
			if (q[63]) begin
				sat = 1'b1;
				return '1;
			end
			q = q << 1;
			r = r << 1;
			if (r >= den) begin
				r = r - den;
				q[0] = 1'b1;
			end
		end
		return q;
	endfunction

	function automatic logic [63:0] int_root(input logic [63:0] x);
		logic [63:0] acc, bitv;
		acc = '0;
		bitv = 64'd1 << 62;
		while (bitv > x) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (x >= acc + bitv) begin
				x = x - (acc + bitv);
				acc = (acc >> 1) + bitv;
			end else begin
				acc = acc >> 1;
			end
			bitv = bitv >> 2;
		end
		return acc;
	endfunction

	// Works out the result of one item and advances the predictor.
	function automatic apu_pkg::res_t adam_predict(input apu_pkg::cmd_t c);
		apu_pkg::res_t r;
		logic [7:0] idx;
		logic [63:0] p1, p2, c1, c2, ag, g2, v, vh, den, am, mh, ratio, stp;
		logic signed [63:0] g, sum, m, nv;
		bit vsat, junk;
		idx = c.entry_index;
		r = '0;
		r.result_index = idx;
		g = 64'(c.operand);
		vsat = 1'b0;
		junk = 1'b0;
		if (c.func == apu_pkg::FUNC_LOAD) begin
			value_tbl[idx] = c.operand;
			mean_tbl[idx] = '0;
			square_tbl[idx] = '0;
			loaded[idx] = 1'b1;
			step_cnt = 20'd1;
			pow1 = apu_pkg::ONE_Q32;
			pow2 = apu_pkg::ONE_Q32;
		end else if (c.func == apu_pkg::FUNC_UPDATE) begin
			if (step_cnt >= limit_q) begin
				r.status = apu_pkg::STAT_REFUSED;
			end else begin
				p1 = (64'(pow1) * beta1_q) >> 16;
				p2 = (64'(pow2) * beta2_q) >> 16;
				c1 = (64'd1 << 32) - p1;
				c2 = (64'd1 << 32) - p2;
				ag = g < 0 ? -g : g;
				g2 = (ag * ag) >> 16;
				sum = $signed(64'(beta1_q)) * mean_tbl[idx]
					+ $signed(64'(65536 - beta1_q)) * g;
				m = sum >>> 16;
				v = (64'(beta2_q) * square_tbl[idx] + (64'd65536 - beta2_q) * g2) >> 16;
				vh = scaled_div(v, 48, c2, vsat);
				den = int_root(vh) + eps_q;
				if (den == 0) den = 64'd1;
				am = m < 0 ? -m : m;
				mh = scaled_div(am, 32, c1, junk);
				ratio = scaled_div(mh, 16, den, junk);
				if (ratio > (64'd1 << 48)) ratio = 64'd1 << 48;
				stp = (ratio * lr_q) >> 16;
				nv = 64'(value_tbl[idx]);
				nv = m < 0 ? nv + $signed(stp) : nv - $signed(stp);
				if (nv > 64'sh7FFF_FFFF) begin
					nv = 64'sh7FFF_FFFF;
					vsat = 1'b1;
				end
				if (nv < -64'sh8000_0000) begin
					nv = -64'sh8000_0000;
					vsat = 1'b1;
				end
				if (vsat) r.status = apu_pkg::STAT_SAT;
				value_tbl[idx] = nv[31:0];
				mean_tbl[idx] = m[31:0];
				square_tbl[idx] = v[47:0];
				if (c.step_end) begin
					pow1 = p1[32:0];
					pow2 = p2[32:0];
					step_cnt = step_cnt + 20'd1;
				end
			end
		end
		r.param_value = value_tbl[idx];
		r.step_number = step_cnt;
		return r;
	endfunction

	// Sends one item, optionally after a random gap; valid stays high into the next item.
	task automatic send_item(input apu_pkg::cmd_t c);
		if (gap_enable && $urandom_range(0, 3) == 0) begin
			cmd_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(negedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= c;
		@(posedge clk);
		while (cmd_stall) @(posedge clk);
		expected_q.push_back(adam_predict(c));
		@(negedge clk);
	endtask

	task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			apu_pkg::REG_LR: lr_q = val[15:0];
			apu_pkg::REG_BETA1: beta1_q = val[15:0];
			apu_pkg::REG_BETA2: beta2_q = val[15:0];
			apu_pkg::REG_EPS: eps_q = val[15:0];
			default: limit_q = val[19:0];
		endcase
	endtask

	task automatic set_regs(input logic [15:0] lr, b1, b2, eps, input logic [19:0] lim);
		reg_write(apu_pkg::REG_LR, 32'(lr));
		reg_write(apu_pkg::REG_BETA1, 32'(b1));
		reg_write(apu_pkg::REG_BETA2, 32'(b2));
		reg_write(apu_pkg::REG_EPS, 32'(eps));
		reg_write(apu_pkg::REG_LIMIT, 32'(lim));
	endtask

	// Drops the input valid and waits until every predicted result has come back.
	task automatic wait_drained;
		cmd_valid <= 1'b0;
		while (expected_q.size() != 0) @(negedge clk);
		repeat (200) @(negedge clk);
	endtask

	function automatic apu_pkg::cmd_t make_item(input logic [1:0] f, input logic [7:0] i,
			input logic [31:0] op, input logic se);
		apu_pkg::cmd_t c;
		c.func = f;
		c.entry_index = i;
		c.operand = op;
		c.step_end = se;
		return c;
	endfunction

	// Random gradient: mostly small, sometimes any 32-bit value.
	function automatic logic [31:0] rand_grad();
		if ($urandom_range(0, 4) == 0) return $urandom();
		return $signed($urandom_range(0, 262143)) - 131072;
	endfunction

	// Pick a random entry in the range; unloaded entries are only loaded.
	function automatic apu_pkg::cmd_t rand_item(input logic [7:0] base, input int span);
		logic [7:0] i;
		int k;
		i = base + 8'($urandom_range(0, span - 1));
		if (!loaded[i])
			return make_item(apu_pkg::FUNC_LOAD, i, $urandom(), 1'($urandom_range(0, 1)));
		k = $urandom_range(0, 19);
		if (k == 0)
			return make_item(apu_pkg::FUNC_LOAD, i, $urandom(), 1'($urandom_range(0, 1)));
		if (k == 1)
			return make_item(apu_pkg::FUNC_READ, i, $urandom(), 1'($urandom_range(0, 1)));
		if (k == 2) return make_item(2'd3, i, $urandom(), 1'($urandom_range(0, 1)));
		return make_item(apu_pkg::FUNC_UPDATE, i, rand_grad(), $urandom_range(0, 3) == 0);
	endfunction

	task automatic test_directed;
		send_item(make_item(apu_pkg::FUNC_LOAD, 8'd0, 32'h7FFF_FFFF, 1'b0));
		send_item(make_item(apu_pkg::FUNC_LOAD, 8'd255, 32'h8000_0000, 1'b1));
		send_item(make_item(apu_pkg::FUNC_UPDATE, 8'd0, 32'h8000_0000, 1'b1));
		send_item(make_item(apu_pkg::FUNC_UPDATE, 8'd255, 32'h7FFF_FFFF, 1'b1));
		send_item(make_item(apu_pkg::FUNC_READ, 8'd0, 32'h0, 1'b0));
		send_item(make_item(2'd3, 8'd255, 32'hFFFF_FFFF, 1'b1));
		send_item(make_item(apu_pkg::FUNC_LOAD, 8'd7, 32'h0001_0000, 1'b0));
		send_item(make_item(apu_pkg::FUNC_UPDATE, 8'd7, 32'h0000_0000, 1'b0));
		send_item(make_item(apu_pkg::FUNC_UPDATE, 8'd7, 32'h0000_8000, 1'b1));
		wait_drained();
		// Zero epsilon with zero gradient gives a zero denominator.
		set_regs(16'hFFFF, 16'd0, 16'd0, 16'd0, 20'd3);
		send_item(make_item(apu_pkg::FUNC_UPDATE, 8'd7, 32'h0, 1'b1));
		send_item(make_item(apu_pkg::FUNC_UPDATE, 8'd7, 32'hFFFF_0000, 1'b1));
		// Step limit reached: updates are refused.
		send_item(make_item(apu_pkg::FUNC_UPDATE, 8'd7, 32'h1234_5678, 1'b1));
		send_item(make_item(apu_pkg::FUNC_LOAD, 8'd7, 32'h8000_0001, 1'b0));
		send_item(make_item(apu_pkg::FUNC_UPDATE, 8'd7, 32'h7FFF_0000, 1'b0));
		wait_drained();
		set_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 20'hFFFFF);
		send_item(make_item(apu_pkg::FUNC_UPDATE, 8'd0, 32'h0FFF_FFFF, 1'b1));
		send_item(make_item(apu_pkg::FUNC_UPDATE, 8'd255, 32'h8000_0000, 1'b0));
		send_item(make_item(apu_pkg::FUNC_UPDATE, 8'd7, 32'h0000_0001, 1'b1));
		wait_drained();
		set_regs(16'd0, 16'd1, 16'd1, 16'd1, 20'd1);
		send_item(make_item(apu_pkg::FUNC_UPDATE, 8'd0, 32'h0000_0001, 1'b1));
		wait_drained();
	endtask

	task automatic test_random(input int count);
		for (int n = 0; n < count; n++) send_item(rand_item(8'd0, 16));
	endtask

	task automatic test_backpressure;
		hold_request = 1'b1;
		for (int n = 0; n < 12; n++) send_item(rand_item(8'd240, 16));
		hold_request = 1'b0;
	endtask

	initial begin
		lr_q = 16'd66;
		beta1_q = 16'd58982;
		beta2_q = 16'd65470;
		eps_q = 16'd1;
		limit_q = 20'd1000;
		step_cnt = 20'd1;
		pow1 = apu_pkg::ONE_Q32;
		pow2 = apu_pkg::ONE_Q32;
		foreach (loaded[i]) loaded[i] = 1'b0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		set_regs(16'd66, 16'd58982, 16'd65470, 16'd1, 20'd1000);
		test_random(250);
		test_backpressure();
		wait_drained();
		set_regs(16'($urandom()), 16'($urandom_range(50000, 65535)),
			16'($urandom_range(60000, 65535)), 16'($urandom_range(0, 100)), 20'd40);
		test_random(250);
		wait_drained();
		set_regs(16'd6553, 16'd58982, 16'd65470, 16'd1, 20'd1000);
		stall_enable = 1'b0;
		gap_enable = 1'b0;
		test_random(150);
		wait_drained();
		if (errors == 0) $display("simulation ok");
		else $display("simulation failed");
		$finish;
	end

	// Receiver stalls: random bursts, or a long hold-off on request.
	initial begin
		forever begin
			@(negedge clk);
			if (hold_request) begin
				res_stall <= 1'b1;
				repeat (400) @(negedge clk);
				res_stall <= 1'b0;
				wait (!hold_request);
			end else if (stall_enable && $urandom_range(0, 7) == 0) begin
				res_stall <= 1'b1;
				repeat ($urandom_range(1, 14)) @(negedge clk);
				res_stall <= 1'b0;
			end
		end
	end

	// Compares each result item with the oldest prediction; also the watchdog.
	always @(posedge clk) begin
		apu_pkg::res_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (expected_q.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result %p", res);
			end else begin
				want = expected_q.pop_front();
				if (res !== want) begin
					errors++;
					if (errors <= 10) $display("mismatch: expected %p actual %p", want, res);
				end
			end
		end
		if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall) || psel) quiet <= 0;
		else quiet <= quiet + 1;
		if (quiet >= QUIET_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

endmodule

`default_nettype wire
